@@ rtl/gcdc_pkg.sv @@
`timescale 1ns / 1ps
// shared types, fixed-point constants and helper functions for the great-circle block
// no dependencies

package gcdc_pkg;

	localparam int FRAC_BITS = 29;
	localparam int GUARD     = 2;
	localparam int WB        = FRAC_BITS + GUARD;
	localparam int NSTEP     = WB;
	localparam int WORD_W    = 40;
	localparam int MUL_W     = 34;
	localparam int SQ_W      = 64;
	localparam int SQ_STEPS  = 32;
	localparam int IN_W      = 128;
	localparam int OUT_W     = 64;
	localparam int SC_LAT    = 34;
	localparam int VEC_LAT   = 32;
	localparam int LAT       = 1 + SC_LAT + 3 + SQ_STEPS + VEC_LAT + 1;

	typedef logic signed [WORD_W-1:0] word_t;

	localparam word_t PI_W      = 40'sd6746518852;
	localparam word_t HALF_PI_W = 40'sd3373259426;
	localparam word_t TWO_PI_W  = 40'sd13493037705;
	localparam word_t ONE_W     = 40'sd2147483648;
	localparam word_t GAIN_W    = 40'sd1304065748;
	localparam word_t PI_F_W     = 40'sd1686629713;
	localparam word_t TWO_PI_F_W = 40'sd3373259426;

	localparam logic [30:0] PI_F     = 31'd1686629713;
	localparam logic [31:0] TWO_PI_F = 32'd3373259426;

	// atan(2^-i) at the internal fraction width
	function automatic word_t step_ang(input int i);
		word_t r;
		case (i)
			0:       r = 40'sd1686629713;
			1:       r = 40'sd995675659;
			2:       r = 40'sd526087673;
			3:       r = 40'sd267050317;
			4:       r = 40'sd134043374;
			5:       r = 40'sd67087031;
			6:       r = 40'sd33551702;
			7:       r = 40'sd16776875;
			8:       r = 40'sd8388565;
			9:       r = 40'sd4194299;
			10:      r = 40'sd2097151;
			default: r = ONE_W >>> i;
		endcase
		return r;
	endfunction

	// fixed-point product, floor rounding
	function automatic word_t fmul(input word_t a, input word_t b);
		logic signed [MUL_W-1:0]   a_n;
		logic signed [MUL_W-1:0]   b_n;
		logic signed [2*MUL_W-1:0] p;
		logic signed [2*MUL_W-1:0] sh;
		a_n = a[MUL_W-1:0];
		b_n = b[MUL_W-1:0];
		p   = a_n * b_n;
		sh  = p >>> WB;
		return sh[WORD_W-1:0];
	endfunction

endpackage

@@ rtl/great_circle_distance_course.sv @@
`timescale 1ns / 1ps
// great-circle distance and initial course between two points, fully pipelined
// depends on gcdc_pkg, gcdc_sincos, gcdc_vec

// Takes one word per clock while the output side keeps tready high and returns one
// result word per input, in order. The latency is set by the 31-step sine/cosine
// cordic pipelines, the 32-step square-root pipeline and the 31-step atan2 cordic
// pipeline in series. A stall on the output freezes the whole pipeline, so s_tready
// follows m_tready whenever a result is waiting. Angles are radians times 2^29,
// longitudes west positive; coincident points give distance 0 and course 0.

module great_circle_distance_course import gcdc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,  // start_lat[30:0], start_lon[62:31], end_lat[93:63], end_lon[125:94]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata   // arc_distance[30:0], initial_course[62:31]
);

	logic en;
	logic [LAT-1:0] vld_q;

	logic signed [30:0] start_lat;
	logic signed [31:0] start_lon;
	logic signed [30:0] end_lat;
	logic signed [31:0] end_lon;
	word_t la, lo, lb, lz;

	word_t lat1_s1, lat2_s1, hdlat_s1, hdlon_s1, dlon_s1;
	word_t sa, ca, sb, cb, hs, gsn, ds, dc;

	word_t p_hs_s2, p_cc_s2, p_gg_s2, p_cs_s2, p_sc_s2, east_s2, dc_s2;
	word_t p_hs_s3, p_hv_s3, p_cs_s3, p_scd_s3, east_s3;
	word_t east_s4, north_s4;
	word_t hav_sum, hav;

	logic [SQ_W-1:0] sqa_v [0:SQ_STEPS];
	logic [SQ_W-1:0] sqa_r [0:SQ_STEPS];
	logic [SQ_W-1:0] sqb_v [0:SQ_STEPS];
	logic [SQ_W-1:0] sqb_r [0:SQ_STEPS];

	word_t ra_w, rb_w, arc_z, crs_z;
	word_t crs_d [1:SQ_STEPS];
	word_t arc2, arc_r, crs_r;
	logic [30:0] arc_f;
	logic [31:0] crs_f;
	logic [OUT_W-1:0] tdata_q;

	assign en       = !vld_q[LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];
	assign m_tdata  = tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	assign start_lat = s_tdata[30:0];
	assign start_lon = s_tdata[62:31];
	assign end_lat   = s_tdata[93:63];
	assign end_lon   = s_tdata[125:94];

	assign la = {{7{start_lat[30]}}, start_lat, 2'b00};
	assign lo = {{6{start_lon[31]}}, start_lon, 2'b00};
	assign lb = {{7{end_lat[30]}}, end_lat, 2'b00};
	assign lz = {{6{end_lon[31]}}, end_lon, 2'b00};

	always_ff @(posedge clk) begin
		if (en) begin
			lat1_s1  <= la;
			lat2_s1  <= lb;
			hdlat_s1 <= (la - lb) >>> 1;
			hdlon_s1 <= (lo - lz) >>> 1;
			dlon_s1  <= lo - lz;
		end
	end

	gcdc_sincos u_sc_lat1 (.clk(clk), .en(en), .ang(lat1_s1), .sin_val(sa), .cos_val(ca));
	gcdc_sincos u_sc_lat2 (.clk(clk), .en(en), .ang(lat2_s1), .sin_val(sb), .cos_val(cb));
	gcdc_sincos u_sc_hlat (.clk(clk), .en(en), .ang(hdlat_s1), .sin_val(hs), .cos_val());
	gcdc_sincos u_sc_hlon (.clk(clk), .en(en), .ang(hdlon_s1), .sin_val(gsn), .cos_val());
	gcdc_sincos u_sc_dlon (.clk(clk), .en(en), .ang(dlon_s1), .sin_val(ds), .cos_val(dc));

	always_comb begin
		hav_sum = p_hs_s3 + p_hv_s3;
		if (hav_sum[WORD_W-1]) begin
			hav = '0;
		end else if (hav_sum > ONE_W) begin
			hav = ONE_W;
		end else begin
			hav = hav_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_hs_s2 <= fmul(hs, hs);
			p_cc_s2 <= fmul(ca, cb);
			p_gg_s2 <= fmul(gsn, gsn);
			p_cs_s2 <= fmul(ca, sb);
			p_sc_s2 <= fmul(sa, cb);
			east_s2 <= fmul(ds, cb);
			dc_s2   <= dc;

			p_hs_s3  <= p_hs_s2;
			p_hv_s3  <= fmul(p_cc_s2, p_gg_s2);
			p_cs_s3  <= p_cs_s2;
			p_scd_s3 <= fmul(p_sc_s2, dc_s2);
			east_s3  <= east_s2;

			east_s4  <= east_s3;
			north_s4 <= p_cs_s3 - p_scd_s3;
			sqa_v[0] <= {1'b0, hav[31:0], 31'b0};
			sqb_v[0] <= {1'b0, 32'(ONE_W - hav), 31'b0};
			sqa_r[0] <= '0;
			sqb_r[0] <= '0;

			// floor square root, one result bit per stage
			for (int k = 0; k < SQ_STEPS; k++) begin
				if (sqa_v[k] >= sqa_r[k] + (64'd1 << (62 - 2 * k))) begin
					sqa_v[k+1] <= sqa_v[k] - (sqa_r[k] + (64'd1 << (62 - 2 * k)));
					sqa_r[k+1] <= (sqa_r[k] >> 1) + (64'd1 << (62 - 2 * k));
				end else begin
					sqa_v[k+1] <= sqa_v[k];
					sqa_r[k+1] <= sqa_r[k] >> 1;
				end
				if (sqb_v[k] >= sqb_r[k] + (64'd1 << (62 - 2 * k))) begin
					sqb_v[k+1] <= sqb_v[k] - (sqb_r[k] + (64'd1 << (62 - 2 * k)));
					sqb_r[k+1] <= (sqb_r[k] >> 1) + (64'd1 << (62 - 2 * k));
				end else begin
					sqb_v[k+1] <= sqb_v[k];
					sqb_r[k+1] <= sqb_r[k] >> 1;
				end
			end
		end
	end

	assign ra_w = {8'b0, sqa_r[SQ_STEPS][31:0]};
	assign rb_w = {8'b0, sqb_r[SQ_STEPS][31:0]};

	gcdc_vec u_vec_arc (.clk(clk), .en(en), .vy(ra_w), .vx(rb_w), .ang(arc_z));
	gcdc_vec u_vec_crs (.clk(clk), .en(en), .vy(east_s4), .vx(north_s4), .ang(crs_z));

	always_ff @(posedge clk) begin
		if (en) begin
			crs_d[1] <= crs_z[WORD_W-1] ? crs_z + TWO_PI_W : crs_z;
			for (int k = 1; k < SQ_STEPS; k++) begin
				crs_d[k+1] <= crs_d[k];
			end
		end
	end

	always_comb begin
		arc2  = arc_z <<< 1;
		arc_r = (arc2 + word_t'(2)) >>> GUARD;
		if (arc_r[WORD_W-1]) begin
			arc_f = '0;
		end else if (arc_r > PI_F_W) begin
			arc_f = PI_F;
		end else begin
			arc_f = arc_r[30:0];
		end
		crs_r = (crs_d[SQ_STEPS] + word_t'(2)) >>> GUARD;
		if (crs_r >= TWO_PI_F_W) begin
			crs_f = 32'(crs_r - TWO_PI_F_W);
		end else begin
			crs_f = crs_r[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tdata_q <= {1'b0, crs_f, arc_f};
		end
	end

endmodule

@@ rtl/gcdc_sincos.sv @@
`timescale 1ns / 1ps
// pipelined rotation cordic giving sine and cosine of one angle per cycle while en is high
// depends on gcdc_pkg

module gcdc_sincos import gcdc_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  word_t ang,
	output word_t sin_val,
	output word_t cos_val
);

	word_t r_s1;
	word_t cx_s [0:NSTEP];
	word_t cy_s [0:NSTEP];
	word_t za_s [0:NSTEP];
	logic [NSTEP:0] flip_s;
	logic [NSTEP:0] zero_s;
	word_t sin_so;
	word_t cos_so;
	word_t wrapped;
	word_t folded;
	logic  fold_flip;
	word_t cx_f;
	word_t cy_f;

	always_comb begin
		if (ang >= PI_W) begin
			wrapped = ang - TWO_PI_W;
		end else if (ang < PI_W - TWO_PI_W) begin
			wrapped = ang + TWO_PI_W;
		end else begin
			wrapped = ang;
		end
	end

	always_comb begin
		if (r_s1 > HALF_PI_W) begin
			folded    = r_s1 - PI_W;
			fold_flip = 1'b1;
		end else if (r_s1 < -HALF_PI_W) begin
			folded    = r_s1 + PI_W;
			fold_flip = 1'b1;
		end else begin
			folded    = r_s1;
			fold_flip = 1'b0;
		end
	end

	always_comb begin
		cx_f = zero_s[NSTEP] ? ONE_W : cx_s[NSTEP];
		cy_f = zero_s[NSTEP] ? '0 : cy_s[NSTEP];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1      <= wrapped;
			cx_s[0]   <= GAIN_W;
			cy_s[0]   <= '0;
			za_s[0]   <= folded;
			flip_s[0] <= fold_flip;
			zero_s[0] <= (folded == '0);
			for (int i = 0; i < NSTEP; i++) begin
				if (!za_s[i][WORD_W-1]) begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					za_s[i+1] <= za_s[i] - step_ang(i);
				end else begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					za_s[i+1] <= za_s[i] + step_ang(i);
				end
				flip_s[i+1] <= flip_s[i];
				zero_s[i+1] <= zero_s[i];
			end
			sin_so <= flip_s[NSTEP] ? -cy_f : cy_f;
			cos_so <= flip_s[NSTEP] ? -cx_f : cx_f;
		end
	end

	assign sin_val = sin_so;
	assign cos_val = cos_so;

endmodule

@@ rtl/gcdc_vec.sv @@
`timescale 1ns / 1ps
// pipelined vectoring cordic giving atan2(vy, vx) one pair per cycle while en is high
// depends on gcdc_pkg

module gcdc_vec import gcdc_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  word_t vy,
	input  word_t vx,
	output word_t ang
);

	word_t vx_s [0:NSTEP];
	word_t vy_s [0:NSTEP];
	word_t za_s [0:NSTEP];
	logic [NSTEP:0] spec_s;
	word_t vx_in;
	word_t vy_in;
	word_t za_in;
	logic  spec_in;

	always_comb begin
		vx_in   = vx;
		vy_in   = vy;
		za_in   = '0;
		spec_in = 1'b0;
		if (vy == '0) begin
			spec_in = 1'b1;
			za_in   = vx[WORD_W-1] ? PI_W : '0;
		end else if (vx == '0) begin
			spec_in = 1'b1;
			za_in   = vy[WORD_W-1] ? -HALF_PI_W : HALF_PI_W;
		end else if (vx[WORD_W-1]) begin
			// fold the left half-plane by pi
			za_in = vy[WORD_W-1] ? -PI_W : PI_W;
			vx_in = -vx;
			vy_in = -vy;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s[0]   <= vx_in;
			vy_s[0]   <= vy_in;
			za_s[0]   <= za_in;
			spec_s[0] <= spec_in;
			for (int i = 0; i < NSTEP; i++) begin
				spec_s[i+1] <= spec_s[i];
				if (spec_s[i]) begin
					vx_s[i+1] <= vx_s[i];
					vy_s[i+1] <= vy_s[i];
					za_s[i+1] <= za_s[i];
				end else if (!vy_s[i][WORD_W-1]) begin
					vx_s[i+1] <= vx_s[i] + (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] - (vx_s[i] >>> i);
					za_s[i+1] <= za_s[i] + step_ang(i);
				end else begin
					vx_s[i+1] <= vx_s[i] - (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] + (vx_s[i] >>> i);
					za_s[i+1] <= za_s[i] - step_ang(i);
				end
			end
		end
	end

	assign ang = za_s[NSTEP];

endmodule

@@ rtl/gcdc_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the great-circle block, bound to the top level
// depends on gcdc_pkg and great_circle_distance_course

module gcdc_checker import gcdc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic [IN_W-1:0]  s_tdata,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// held output word stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// input side only stalls behind a waiting result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	a_arc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[30:0] <= PI_F)
		else $error("distance above pi");

	a_crs: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[62:31] < TWO_PI_F && !m_tdata[63])
		else $error("course out of range");

endmodule

bind great_circle_distance_course gcdc_checker u_gcdc_checker (.*);
